[src/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the complex polyphase resampler
// Controller states, command and status bundles, register indexes, input
// function codes and the fixed field widths of the coefficient and config paths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    // Fixed field widths.
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 15;
    localparam int COEF_INDEX_W = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int FACTOR_REG_W = 5;
    localparam int TAPS_REG_W   = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

    // Input function codes.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PHASE,
        ST_MAC,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_sample;
        logic wr_coef;
        logic mac_start;
        logic mac_issue;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[src/cpr_ram.sv]
// ----------------------------------------------------------------------------
// cpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl: resampler controller
// Holds the configuration registers, walks the phases of each sample item,
// keeps the decimation counter and steps the coefficient index of the MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl #(
    parameter int MAX_TAPS   = 64,
    parameter int MAX_FACTOR = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [cpr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [cpr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_func,
    output cpr_pkg::t_cmd                            o_cmd,
    output logic      [$clog2(MAX_TAPS)-1:0]         o_coef_addr,
    input  cpr_pkg::t_status                         i_status
);

    import cpr_pkg::*;

    localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
    localparam int LIM_W0 = $clog2(MAX_TAPS + MAX_FACTOR + 1);
    localparam int LIM_W  = (LIM_W0 > 8) ? LIM_W0 : 8;
    localparam int TA_W   = $clog2(MAX_TAPS);

    t_state                  r_state, n_state;
    logic [FACTOR_REG_W-1:0] r_interp, r_decim;
    logic [TAPS_REG_W-1:0]   r_taps;
    logic [FAC_W-1:0]        r_p, n_p;
    logic [FAC_W-1:0]        r_dec, n_dec;
    logic [LIM_W-1:0]        r_ci, n_ci;
    logic [LIM_W-1:0]        r_lim, n_lim;

    logic [6:0]       interp7, decim7, ni7, nd7;
    logic [FAC_W-1:0] fac_i, fac_d;
    logic [LIM_W-1:0] taps_l;
    logic [FAC_W:0]   dec_inc;
    logic [FAC_W-1:0] dec_adv;
    logic             accepted, phase_last, mac_more, out_last, load_ok;
    t_cmd             cmd;

    // Factors of zero act as one, factors above the maximum act as the maximum.
    assign interp7 = {2'b00, r_interp};
    assign decim7  = {2'b00, r_decim};
    assign ni7 = (interp7 == 7'd0) ? 7'd1 :
                 (interp7 > 7'(MAX_FACTOR)) ? 7'(MAX_FACTOR) : interp7;
    assign nd7 = (decim7 == 7'd0) ? 7'd1 :
                 (decim7 > 7'(MAX_FACTOR)) ? 7'(MAX_FACTOR) : decim7;
    assign fac_i = FAC_W'(ni7);
    assign fac_d = FAC_W'(nd7);
    assign taps_l = (LIM_W'(r_taps) > LIM_W'(MAX_TAPS)) ? LIM_W'(MAX_TAPS) : LIM_W'(r_taps);

    assign accepted   = i_valid && (r_state == ST_IDLE);
    assign phase_last = ((FAC_W+1)'(r_p) + (FAC_W+1)'(1)) == (FAC_W+1)'(fac_i);

    // A stale counter at or above the factor wraps to zero on its next step.
    assign dec_inc = (FAC_W+1)'(r_dec) + (FAC_W+1)'(1);
    assign dec_adv = (dec_inc >= (FAC_W+1)'(fac_d)) ? '0 : FAC_W'(dec_inc);

    // Tap j runs while (j+1)*interp_factor fits in the tap count.
    assign mac_more = r_lim <= taps_l;

    // The next emission after phase p comes at phase p + decim_factor.
    assign out_last = ((FAC_W+1)'(r_p) + (FAC_W+1)'(fac_d)) >= (FAC_W+1)'(fac_i);
    assign load_ok  = !i_status.pipe_busy && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_interp <= FACTOR_REG_W'(1);
            r_decim  <= FACTOR_REG_W'(1);
            r_taps   <= TAPS_REG_W'(1);
            r_p      <= '0;
            r_dec    <= '0;
            r_ci     <= '0;
            r_lim    <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_dec   <= n_dec;
            r_ci    <= n_ci;
            r_lim   <= n_lim;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INTERP: r_interp <= i_cfg_data[FACTOR_REG_W-1:0];
                    CFG_DECIM:  r_decim  <= i_cfg_data[FACTOR_REG_W-1:0];
                    CFG_TAPS:   r_taps   <= i_cfg_data[TAPS_REG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accepted && (i_func == FUNC_SAMPLE)) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (r_dec == '0) begin
                    n_state = ST_MAC;
                end else if (phase_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (!mac_more) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_ok) begin
                    n_state = phase_last ? ST_IDLE : ST_PHASE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd   = '0;
        n_p   = r_p;
        n_dec = r_dec;
        n_ci  = r_ci;
        n_lim = r_lim;
        unique case (r_state)
            ST_IDLE: begin
                if (accepted) begin
                    if (i_func == FUNC_COEF) begin
                        cmd.wr_coef = 1'b1;
                    end else begin
                        cmd.wr_sample = 1'b1;
                        n_p = '0;
                    end
                end
            end
            ST_PHASE: begin
                if (r_dec == '0) begin
                    cmd.mac_start = 1'b1;
                    n_ci  = LIM_W'(r_p);
                    n_lim = LIM_W'(fac_i);
                end else begin
                    n_dec = dec_adv;
                    n_p   = r_p + FAC_W'(1);
                end
            end
            ST_MAC: begin
                if (mac_more) begin
                    cmd.mac_issue = 1'b1;
                    n_ci  = r_ci + LIM_W'(fac_i);
                    n_lim = r_lim + LIM_W'(fac_i);
                end
            end
            ST_DRAIN: begin
                if (load_ok) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = out_last;
                    n_dec = dec_adv;
                    n_p   = r_p + FAC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_coef_addr = r_ci[TA_W-1:0];

endmodule

`default_nettype wire

[src/cpr_dp.sv]
// ----------------------------------------------------------------------------
// cpr_dp: resampler datapath
// Circular delay line and coefficient store in RAM, a pipelined complex MAC,
// the scale and saturate step and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_dp #(
    parameter int MAX_TAPS   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  cpr_pkg::t_cmd                               i_cmd,
    output cpr_pkg::t_status                            o_status,
    input  wire logic signed [DATA_WIDTH-1:0]           i_sample_re,
    input  wire logic signed [DATA_WIDTH-1:0]           i_sample_im,
    input  wire logic        [cpr_pkg::COEF_INDEX_W-1:0] i_coef_index,
    input  wire logic signed [cpr_pkg::COEF_W-1:0]      i_coef_re,
    input  wire logic signed [cpr_pkg::COEF_W-1:0]      i_coef_im,
    input  wire logic        [$clog2(MAX_TAPS)-1:0]     i_coef_addr,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed      [DATA_WIDTH-1:0]           o_out_re,
    output logic signed      [DATA_WIDTH-1:0]           o_out_im,
    output logic                                        o_saturated,
    output logic                                        o_last
);

    import cpr_pkg::*;

    localparam int DA_W   = $clog2(MAX_TAPS);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = DATA_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 2 + $clog2(MAX_TAPS);
    localparam int SH_W   = ACC_W - FRAC_BITS;
    localparam int N_IDX  = 2 ** COEF_INDEX_W;

    logic [DA_W-1:0] r_wp, n_wp;
    logic [TW-1:0]   r_fill;
    logic [DA_W-1:0] r_daddr;
    logic [TW-1:0]   r_j;
    logic            r_v1, r_z1, r_v2;

    logic [2*DATA_WIDTH-1:0] delay_rdata;
    logic [2*COEF_W-1:0]     coef_rdata;
    logic [DA_W-1:0]         idx_mod [N_IDX];

    logic signed [DATA_WIDTH-1:0] d_re, d_im;
    logic signed [COEF_W-1:0]     c_re, c_im;
    logic signed [PROD_W-1:0]     r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0]      r_acc_re, r_acc_im;
    logic        [DATA_WIDTH:0]   res_re, res_im;

    logic                         r_ovalid;
    logic signed [DATA_WIDTH-1:0] r_out_re, r_out_im;
    logic                         r_sat, r_last;

    // Coefficient index reduced modulo the store depth, as a constant table.
    for (genvar k = 0; k < N_IDX; k++) begin : g_idx
        assign idx_mod[k] = DA_W'(k % MAX_TAPS);
    end

    assign n_wp = (r_wp == DA_W'(MAX_TAPS - 1)) ? '0 : r_wp + DA_W'(1);

    cpr_ram #(
        .WIDTH (2 * DATA_WIDTH),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_sample),
        .i_waddr (n_wp),
        .i_wdata ({i_sample_re, i_sample_im}),
        .i_raddr (r_daddr),
        .o_rdata (delay_rdata)
    );

    cpr_ram #(
        .WIDTH (2 * COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_coef),
        .i_waddr (idx_mod[i_coef_index]),
        .i_wdata ({i_coef_re, i_coef_im}),
        .i_raddr (i_coef_addr),
        .o_rdata (coef_rdata)
    );

    // The delay line counts as zero beyond the number of samples seen so far.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cmd.wr_sample) begin
                r_wp <= n_wp;
                if (r_fill != TW'(MAX_TAPS)) begin
                    r_fill <= r_fill + TW'(1);
                end
            end
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_daddr <= r_wp;
            r_j     <= '0;
        end else if (i_cmd.mac_issue) begin
            r_daddr <= (r_daddr == '0) ? DA_W'(MAX_TAPS - 1) : r_daddr - DA_W'(1);
            r_j     <= r_j + TW'(1);
        end
        if (i_cmd.mac_issue) begin
            r_z1 <= (r_j >= r_fill);
        end
    end

    assign d_re = r_z1 ? '0 : delay_rdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign d_im = r_z1 ? '0 : delay_rdata[DATA_WIDTH-1:0];
    assign c_re = coef_rdata[2*COEF_W-1:COEF_W];
    assign c_im = coef_rdata[COEF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_p_rr <= d_re * c_re;
            r_p_ii <= d_im * c_im;
            r_p_ri <= d_re * c_im;
            r_p_ir <= d_im * c_re;
        end
        if (i_cmd.mac_start) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
            r_acc_im <= r_acc_im + ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
        end
    end

    // Floor shift by the fraction bits, then clip; the top bit flags a clip.
    function automatic logic [DATA_WIDTH:0] scale_clip(input logic [ACC_W-1:0] acc);
        logic [SH_W-1:0]         sh;
        logic [SH_W-DATA_WIDTH:0] upper;
        logic [DATA_WIDTH:0]     res;
        sh    = acc[ACC_W-1:FRAC_BITS];
        upper = sh[SH_W-1:DATA_WIDTH-1];
        if ((&upper) || !(|upper)) begin
            res = {1'b0, sh[DATA_WIDTH-1:0]};
        end else if (sh[SH_W-1]) begin
            res = {1'b1, 1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    assign res_re = scale_clip(r_acc_re);
    assign res_im = scale_clip(r_acc_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_re <= res_re[DATA_WIDTH-1:0];
            r_out_im <= res_im[DATA_WIDTH-1:0];
            r_sat    <= res_re[DATA_WIDTH] | res_im[DATA_WIDTH];
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = !r_ovalid || !i_stall;

    assign o_valid     = r_ovalid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_saturated = r_sat;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[src/complex_polyphase_resampler.sv]
// ----------------------------------------------------------------------------
// complex_polyphase_resampler: complex rational resampler, top level
// Usage:
//   Input channel (i_valid / o_stall): an item with i_func = 0 shifts one
//   complex sample into the delay line; i_func = 1 writes one coefficient.
//   Output channel (o_valid / i_stall): one filtered complex item per kept
//   phase; o_last marks the final item caused by a sample.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   interpolation factor, 1 the decimation factor, 2 the tap count.
//   Rate: a coefficient item is written when it is taken. A sample item
//   enters, passes each decimated phase without MAC work, and per kept
//   phase one shared complex MAC reads one delay entry and one coefficient
//   from RAM per cycle, then a read, multiply and accumulate pipeline drains.
//   One item is worked on at a time; o_stall is high until it is finished.
//   When i_stall holds a result, the next phase is computed and waits until
//   the output register frees up. Synchronous reset clears the delay line
//   (through a fill count), the decimation counter and the registers
//   (factors and tap count back to 1); the coefficient store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module complex_polyphase_resampler #(
    parameter int MAX_TAPS   = 64,
    parameter int MAX_FACTOR = 16,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic        [cpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic        [cpr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic                                    i_func,
    input  wire logic signed [DATA_WIDTH-1:0]            i_sample_re,
    input  wire logic signed [DATA_WIDTH-1:0]            i_sample_im,
    input  wire logic        [cpr_pkg::COEF_INDEX_W-1:0] i_coef_index,
    input  wire logic signed [cpr_pkg::COEF_W-1:0]       i_coef_re,
    input  wire logic signed [cpr_pkg::COEF_W-1:0]       i_coef_im,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic signed      [DATA_WIDTH-1:0]            o_out_re,
    output logic signed      [DATA_WIDTH-1:0]            o_out_im,
    output logic                                         o_saturated,
    output logic                                         o_last
);

    import cpr_pkg::*;

    t_cmd                  cmd;
    t_status               st;
    logic [$clog2(MAX_TAPS)-1:0] coef_addr;

    cpr_ctrl #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .o_cmd       (cmd),
        .o_coef_addr (coef_addr),
        .i_status    (st)
    );

    cpr_dp #(
        .MAX_TAPS   (MAX_TAPS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (st),
        .i_sample_re  (i_sample_re),
        .i_sample_im  (i_sample_im),
        .i_coef_index (i_coef_index),
        .i_coef_re    (i_coef_re),
        .i_coef_im    (i_coef_im),
        .i_coef_addr  (coef_addr),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_re     (o_out_re),
        .o_out_im     (o_out_im),
        .o_saturated  (o_saturated),
        .o_last       (o_last)
    );

`ifndef ASSERT_OFF
    // A result is taken from the accumulator only after every tap has landed.
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !st.pipe_busy)
        else $error("result loaded while MAC pipeline busy");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

    // Stores are written only for an accepted item.
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_sample || cmd.wr_coef) |-> (i_valid && !o_stall))
        else $error("store written without an accepted item");

    // A sample item keeps the input side stalled while its phases run.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_sample |=> o_stall)
        else $error("input not stalled after a sample item");
`endif

endmodule

`default_nettype wire
